// ===== hdl/source_line_classifier_defines.svh =====
// Assertion macros for the source line classifier.
`ifndef SOURCE_LINE_CLASSIFIER_DEFINES_SVH
`define SOURCE_LINE_CLASSIFIER_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled while in reset.
`define SLC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("source_line_classifier: assertion failed");
// Next-cycle implication, disabled while in reset.
`define SLC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("source_line_classifier: assertion failed");
`else
`define SLC_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define SLC_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== hdl/slc_pkg.sv =====
package slc_pkg;

    // Language register
    localparam int unsigned LANG_W = 3;
    localparam logic [LANG_W-1:0] LANG_TEXT   = 3'd0;
    localparam logic [LANG_W-1:0] LANG_C      = 3'd1;
    localparam logic [LANG_W-1:0] LANG_M      = 3'd2;
    localparam logic [LANG_W-1:0] LANG_SHELL  = 3'd3;
    localparam logic [LANG_W-1:0] LANG_BATCH  = 3'd4;
    localparam logic [LANG_W-1:0] LANG_PYTHON = 3'd5;
    localparam logic [LANG_W-1:0] LANG_RESET  = LANG_C;

    // Byte codes
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_E     = 8'h45;
    localparam logic [7:0] CH_M     = 8'h4D;
    localparam logic [7:0] CH_R     = 8'h52;

    // Line comment prefix length per language (unused codes have none)
    function automatic logic [1:0] lead_len(input logic [LANG_W-1:0] lang);
        logic [1:0] len;
        unique case (lang)
            LANG_C, LANG_M:          len = 2'd2;
            LANG_SHELL, LANG_PYTHON: len = 2'd1;
            LANG_BATCH:              len = 2'd3;
            default:                 len = 2'd0;
        endcase
        return len;
    endfunction

    // Prefix byte at a position; callers guard with lead_len
    function automatic logic [7:0] lead_char(input logic [LANG_W-1:0] lang,
                                             input logic [1:0] pos);
        logic [7:0] ch;
        ch = CH_NUL;
        unique case (lang)
            LANG_C, LANG_M:          ch = (pos < 2'd2) ? CH_SLASH : CH_NUL;
            LANG_SHELL, LANG_PYTHON: ch = (pos == 2'd0) ? CH_HASH : CH_NUL;
            LANG_BATCH: begin
                unique case (pos)
                    2'd0:    ch = CH_R;
                    2'd1:    ch = CH_E;
                    2'd2:    ch = CH_M;
                    default: ch = CH_NUL;
                endcase
            end
            default:                 ch = CH_NUL;
        endcase
        return ch;
    endfunction

    // Languages with nesting block comments
    function automatic logic has_block(input logic [LANG_W-1:0] lang);
        return (lang == LANG_C) || (lang == LANG_M);
    endfunction

    function automatic logic is_space(input logic [7:0] b);
        return (b == CH_SPACE) || (b == CH_TAB) || (b == CH_VT) ||
               (b == CH_FF) || (b == CH_CR);
    endfunction

endpackage

// ===== hdl/slc_parser.sv =====
// Per-byte line parser: mode, prefix match, block nesting and line counters.
// Count outputs are the next-state values, valid in the cycle of i_step.
module slc_parser #(
    parameter int unsigned COUNT_WIDTH = 32,
    parameter int unsigned NEST_WIDTH  = 8
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_step,
    input  logic [7:0]                   i_byte,
    input  logic                         i_last,
    input  logic [slc_pkg::LANG_W-1:0]   i_lang,
    output logic [COUNT_WIDTH-1:0]       o_total,
    output logic [COUNT_WIDTH-1:0]       o_comment,
    output logic [COUNT_WIDTH-1:0]       o_empty
);

    typedef enum logic [2:0] {
        MODE_START,
        MODE_PREFIX,
        MODE_CODE,
        MODE_COMMENT,
        MODE_BLOCK
    } t_mode;

    typedef enum logic [1:0] {
        PEND_NONE,
        PEND_SLASH,
        PEND_STAR
    } t_pend;

    localparam logic [COUNT_WIDTH-1:0] CNT_MAX   = '1;
    localparam logic [NEST_WIDTH-1:0]  DEPTH_MAX = '1;
    localparam logic [NEST_WIDTH-1:0]  DEPTH_ONE = NEST_WIDTH'(1);

    t_mode                   r_mode,    n_mode;
    logic [1:0]              r_pos,     n_pos;
    t_pend                   r_pend,    n_pend;
    logic [NEST_WIDTH-1:0]   r_depth,   n_depth;
    logic [COUNT_WIDTH-1:0]  r_total,   n_total;
    logic [COUNT_WIDTH-1:0]  r_comment, n_comment;
    logic [COUNT_WIDTH-1:0]  r_empty,   n_empty;

    logic [1:0] len;
    logic [2:0] pos_inc;
    logic       nl;
    logic       prefix_hit;

    function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] x);
        return (x != CNT_MAX) ? x + COUNT_WIDTH'(1) : x;
    endfunction

    assign len        = slc_pkg::lead_len(i_lang);
    assign pos_inc    = {1'b0, r_pos} + 3'd1;
    assign nl         = (i_byte == slc_pkg::CH_NL);
    assign prefix_hit = (r_pos < len) && (i_byte == slc_pkg::lead_char(i_lang, r_pos));

    // Next state for one byte
    always_comb begin
        n_mode    = r_mode;
        n_pos     = r_pos;
        n_pend    = r_pend;
        n_depth   = r_depth;
        n_total   = r_total;
        n_comment = r_comment;
        n_empty   = r_empty;
        unique case (r_mode)
            MODE_START: begin
                if (slc_pkg::is_space(i_byte)) begin
                    n_mode = MODE_START;
                end else if ((len != 2'd0) &&
                             (i_byte == slc_pkg::lead_char(i_lang, 2'd0))) begin
                    if (len == 2'd1) begin
                        n_mode = MODE_COMMENT;
                    end else begin
                        n_mode = MODE_PREFIX;
                        n_pos  = 2'd1;
                    end
                end else if (nl) begin
                    n_empty = sat_inc(r_empty);
                    n_total = sat_inc(r_total);
                end else begin
                    n_mode = MODE_CODE;
                end
            end
            MODE_PREFIX: begin
                if (prefix_hit) begin
                    if (pos_inc >= {1'b0, len}) begin
                        n_mode = MODE_COMMENT;
                        n_pos  = 2'd0;
                    end else begin
                        n_pos = pos_inc[1:0];
                    end
                end else if ((r_pos == 2'd1) && slc_pkg::has_block(i_lang) &&
                             (i_byte == slc_pkg::CH_STAR)) begin
                    n_mode  = MODE_BLOCK;
                    n_depth = DEPTH_ONE;
                    n_pend  = PEND_NONE;
                    n_pos   = 2'd0;
                end else begin
                    // failed prefix: this byte is a code byte
                    n_pos = 2'd0;
                    if (nl) begin
                        n_total = sat_inc(r_total);
                        n_mode  = MODE_START;
                    end else begin
                        n_mode = MODE_CODE;
                    end
                end
            end
            MODE_CODE: begin
                if (nl) begin
                    n_total = sat_inc(r_total);
                    n_mode  = MODE_START;
                end
            end
            MODE_COMMENT: begin
                if (nl) begin
                    n_comment = sat_inc(r_comment);
                    n_total   = sat_inc(r_total);
                    n_mode    = MODE_START;
                end
            end
            MODE_BLOCK: begin
                priority if ((r_pend == PEND_SLASH) && (i_byte == slc_pkg::CH_STAR)) begin
                    if (r_depth != DEPTH_MAX) n_depth = r_depth + DEPTH_ONE;
                    n_pend = PEND_NONE;
                end else if ((r_pend == PEND_STAR) && (i_byte == slc_pkg::CH_SLASH)) begin
                    n_pend = PEND_NONE;
                    if (r_depth <= DEPTH_ONE) begin
                        n_depth = '0;
                        n_mode  = MODE_COMMENT;
                    end else begin
                        n_depth = r_depth - DEPTH_ONE;
                    end
                end else if (i_byte == slc_pkg::CH_SLASH) begin
                    n_pend = PEND_SLASH;
                end else if (i_byte == slc_pkg::CH_STAR) begin
                    n_pend = PEND_STAR;
                end else begin
                    n_pend = PEND_NONE;
                    if (nl) begin
                        n_comment = sat_inc(r_comment);
                        n_total   = sat_inc(r_total);
                    end
                end
            end
            default: begin
                n_mode = MODE_START;
            end
        endcase
    end

    // State registers; the final byte of a file clears everything
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_step && i_last)) begin
            r_mode    <= MODE_START;
            r_pos     <= 2'd0;
            r_pend    <= PEND_NONE;
            r_depth   <= '0;
            r_total   <= '0;
            r_comment <= '0;
            r_empty   <= '0;
        end else if (i_step) begin
            r_mode    <= n_mode;
            r_pos     <= n_pos;
            r_pend    <= n_pend;
            r_depth   <= n_depth;
            r_total   <= n_total;
            r_comment <= n_comment;
            r_empty   <= n_empty;
        end
    end

    assign o_total   = n_total;
    assign o_comment = n_comment;
    assign o_empty   = n_empty;

endmodule

// ===== hdl/source_line_classifier.sv =====
// Source line classifier: takes a file one byte per transfer and, on the byte
// flagged last, returns one result with the total, comment, empty and code line
// counts for the language held in the configuration register (reset: C). One
// byte is taken every cycle; the input stalls only while a last byte waits for
// room in the two-deep result pipeline. A byte is registered and parsed in the
// next cycle unless a last byte stalls; its counts go to the count capture
// register, then with code lines subtracted to the output register.
// Counters saturate at 2^COUNT_WIDTH - 1 and outputs carry the low 32 bits.
// Write the language register only while no file is in flight.
`include "source_line_classifier_defines.svh"

module source_line_classifier #(
    parameter int unsigned COUNT_WIDTH = 32,
    parameter int unsigned NEST_WIDTH  = 8
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // configuration
    input  logic                        i_cfg_we,
    input  logic [slc_pkg::LANG_W-1:0]  i_cfg_data,
    // byte input
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [7:0]                  i_in_byte,
    input  logic                        i_last_byte,
    // result output
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [31:0]                 o_all_lines,
    output logic [31:0]                 o_comment_lines,
    output logic [31:0]                 o_blank_lines,
    output logic [31:0]                 o_code_lines
);

    localparam int unsigned OUT_W = 32;
    localparam int unsigned EXT_W = COUNT_WIDTH + OUT_W;

    logic [slc_pkg::LANG_W-1:0] r_lang;

    logic                       r_in_valid;
    logic [7:0]                 r_in_byte;
    logic                       r_in_last;

    logic                       r_res_valid;
    logic [COUNT_WIDTH-1:0]     r_res_total, r_res_comment, r_res_empty;

    logic                       r_out_valid;
    logic [COUNT_WIDTH-1:0]     r_out_total, r_out_comment, r_out_empty, r_out_code;

    logic [COUNT_WIDTH-1:0]     n_total, n_comment, n_empty, n_code;
    logic [COUNT_WIDTH:0]       used;
    logic                       out_adv;
    logic                       res_free;
    logic                       step;
    logic [EXT_W-1:0]           ext_total, ext_comment, ext_empty, ext_code;

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lang <= slc_pkg::LANG_RESET;
        end else if (i_cfg_we) begin
            r_lang <= i_cfg_data;
        end
    end

    // Pipeline flow control
    assign out_adv  = !r_out_valid || !i_stall;
    assign res_free = !r_res_valid || out_adv;
    assign step     = r_in_valid && (!r_in_last || res_free);
    assign o_stall  = r_in_valid && r_in_last && !res_free;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_in_byte <= i_in_byte;
            r_in_last <= i_last_byte;
        end
    end

    slc_parser #(
        .COUNT_WIDTH (COUNT_WIDTH),
        .NEST_WIDTH  (NEST_WIDTH)
    ) u_parser (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (step),
        .i_byte    (r_in_byte),
        .i_last    (r_in_last),
        .i_lang    (r_lang),
        .o_total   (n_total),
        .o_comment (n_comment),
        .o_empty   (n_empty)
    );

    // Count capture on the last byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else if (step && r_in_last) begin
            r_res_valid <= 1'b1;
        end else if (out_adv) begin
            r_res_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && r_in_last) begin
            r_res_total   <= n_total;
            r_res_comment <= n_comment;
            r_res_empty   <= n_empty;
        end
    end

    // Code lines: total minus comment minus empty, floored at zero
    assign used   = {1'b0, r_res_comment} + {1'b0, r_res_empty};
    assign n_code = (used > {1'b0, r_res_total}) ? '0 : r_res_total - used[COUNT_WIDTH-1:0];

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_adv) begin
            r_out_valid <= r_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_adv && r_res_valid) begin
            r_out_total   <= r_res_total;
            r_out_comment <= r_res_comment;
            r_out_empty   <= r_res_empty;
            r_out_code    <= n_code;
        end
    end

    // Low 32 bits of each count, zero-extended for narrow counters
    assign ext_total   = {OUT_W'(0), r_out_total};
    assign ext_comment = {OUT_W'(0), r_out_comment};
    assign ext_empty   = {OUT_W'(0), r_out_empty};
    assign ext_code    = {OUT_W'(0), r_out_code};

    assign o_valid         = r_out_valid;
    assign o_all_lines     = ext_total[OUT_W-1:0];
    assign o_comment_lines = ext_comment[OUT_W-1:0];
    assign o_blank_lines   = ext_empty[OUT_W-1:0];
    assign o_code_lines    = ext_code[OUT_W-1:0];

    // Checks
    `SLC_ASSERT_IMPL(a_stall_only_on_last, i_clk, i_rst_n, o_stall, r_in_valid && r_in_last)
    `SLC_ASSERT_IMPL(a_code_within_total, i_clk, i_rst_n, r_out_valid, r_out_code <= r_out_total)
    `SLC_ASSERT_NEXT(a_out_drains, i_clk, i_rst_n,
        r_out_valid && !i_stall && !r_res_valid, !r_out_valid)
    `SLC_ASSERT_NEXT(a_last_captured, i_clk, i_rst_n, step && r_in_last, r_res_valid)

endmodule
